### design/icf_pkg.sv
// package with types, operation codes and helpers of the constant fold alu
`default_nettype none
package icf_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned OP_W = 5;
    localparam int unsigned SIZE_W = 3;
    // one restoring step per cell
    localparam int unsigned NUM_CELLS = DATA_W;

    typedef enum logic [OP_W-1:0] {
        OP_PLUS  = 5'd0,
        OP_NEG   = 5'd1,
        OP_NOT   = 5'd2,
        OP_LNOT  = 5'd3,
        OP_CAST  = 5'd4,
        OP_MUL   = 5'd5,
        OP_DIV   = 5'd6,
        OP_MOD   = 5'd7,
        OP_ADD   = 5'd8,
        OP_SUB   = 5'd9,
        OP_SHL   = 5'd10,
        OP_SHR   = 5'd11,
        OP_AND   = 5'd12,
        OP_XOR   = 5'd13,
        OP_OR    = 5'd14,
        OP_LT    = 5'd15,
        OP_GT    = 5'd16,
        OP_LE    = 5'd17,
        OP_GE    = 5'd18,
        OP_EQ    = 5'd19,
        OP_NE    = 5'd20,
        OP_LAND  = 5'd21,
        OP_LOR   = 5'd22,
        OP_SEQ   = 5'd23
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]   req_type;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic              signed_op;
        logic [SIZE_W-1:0] cast_size;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic              folded;
    } rsp_t;

    // what travels down the chain with every item
    typedef struct packed {
        logic              valid;
        logic              is_div;    // result comes from the divider
        logic              is_mod;
        logic              neg_res;   // negate the divider result
        logic [DATA_W-1:0] simple;    // result of every other operation
        logic              folded;
        logic [DATA_W-1:0] rem;       // partial remainder
        logic [DATA_W-1:0] quo;       // dividend bits shifting out, quotient in
        logic [DATA_W-1:0] divisor;
    } lane_t;

    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (DATA_W'(0) - v) : v;
    endfunction

endpackage
`default_nettype wire

### design/int32_constant_fold_alu.sv
// top level of the 32-bit constant fold alu: front stage, divide chain, output stage
//
//  channel  direction  payload          handshake
//  req      in         icf_pkg::req_t   req_valid / req_stall
//  rsp      out        icf_pkg::rsp_t   rsp_valid / rsp_stall
//
// one item accepted per cycle while req_stall is low; the result leaves from the last cell.
// the chain has 32 divide cells, one quotient bit per cell.
// every operation passes through the same chain so results stay in order.
// a stall on rsp freezes the whole chain when the last cell holds an item;
// req_stall follows rsp_stall only then.
// reset clears every cell.
`default_nettype none
module int32_constant_fold_alu (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           req_valid,
    output logic          req_stall,
    input  wire icf_pkg::req_t req,
    output logic          rsp_valid,
    input  wire           rsp_stall,
    output icf_pkg::rsp_t rsp
);
    localparam int unsigned W = icf_pkg::DATA_W;
    localparam int unsigned NUM_CELLS = icf_pkg::NUM_CELLS;

    icf_pkg::lane_t chain [0:NUM_CELLS];
    logic           advance;
    logic [W-1:0]   div_r;
    logic [W-1:0]   res_r;

    // the chain only holds up when a finished item cannot leave
    assign advance = !(chain[NUM_CELLS].valid && rsp_stall);
    assign req_stall = !advance;

    icf_front u_front (
        .req   (req),
        .valid (req_valid),
        .lane  (chain[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        icf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .lane_in  (chain[i]),
            .lane_out (chain[i+1])
        );
    end

    always_comb
    begin
        div_r = chain[NUM_CELLS].is_mod ? chain[NUM_CELLS].rem : chain[NUM_CELLS].quo;
        if (chain[NUM_CELLS].neg_res)
        begin
            div_r = W'(0) - div_r;
        end
        res_r = chain[NUM_CELLS].is_div ? div_r : chain[NUM_CELLS].simple;
        if (!chain[NUM_CELLS].folded)
        begin
            res_r = '0;
        end
    end

    assign rsp_valid = chain[NUM_CELLS].valid;
    assign rsp.result_value = res_r;
    assign rsp.folded = chain[NUM_CELLS].folded;

endmodule
`default_nettype wire

### design/icf_front.sv
// front stage: decodes the item, computes the simple operations and the product
`default_nettype none
module icf_front (
    input  wire icf_pkg::req_t req,
    input  wire                valid,
    output icf_pkg::lane_t     lane
);
    localparam int unsigned W = icf_pkg::DATA_W;

    logic [W-1:0] a;
    logic [W-1:0] b;
    logic         sgn;
    logic [4:0]   sh;
    logic         lt_ab;
    logic         lt_ba;
    logic [W-1:0] cast_mask;
    logic [W-1:0] cast_v;
    logic         cast_top;
    logic [2*W-1:0] sra_wide;
    logic [W-1:0] r;
    logic         ok;
    logic         na;
    logic         nb;

    always_comb
    begin
        a = req.operand_a;
        b = req.operand_b;
        sgn = req.signed_op;
        sh = b[4:0];
        na = a[W-1];
        nb = b[W-1];
        lt_ab = (sgn && (na != nb)) ? na : (a < b);
        lt_ba = (sgn && (na != nb)) ? nb : (b < a);
        cast_mask = '1;
        cast_top = 1'b0;
        case (req.cast_size)
            3'd1:
            begin
                cast_mask = 32'h0000_00ff;
                cast_top = a[7];
            end
            3'd2:
            begin
                cast_mask = 32'h0000_ffff;
                cast_top = a[15];
            end
            3'd3:
            begin
                cast_mask = 32'h00ff_ffff;
                cast_top = a[23];
            end
            default:
            begin
                cast_mask = '1;
                cast_top = 1'b0;
            end
        endcase
        cast_v = a & cast_mask;
        if (sgn && cast_top)
        begin
            cast_v = cast_v | ~cast_mask;
        end
        sra_wide = {((sgn && na) ? {W{1'b1}} : {W{1'b0}}), a} >> sh;
        r = '0;
        ok = 1'b1;
        unique case (req.req_type) inside
            icf_pkg::OP_PLUS:  r = a;
            icf_pkg::OP_NEG:   r = W'(0) - a;
            icf_pkg::OP_NOT:   r = ~a;
            icf_pkg::OP_LNOT:  r = {{(W-1){1'b0}}, (a == '0)};
            icf_pkg::OP_CAST:  r = cast_v;
            icf_pkg::OP_MUL:   r = a * b;
            icf_pkg::OP_DIV, icf_pkg::OP_MOD: ok = (b != '0);
            icf_pkg::OP_ADD:   r = a + b;
            icf_pkg::OP_SUB:   r = a - b;
            icf_pkg::OP_SHL:   r = a << sh;
            icf_pkg::OP_SHR:   r = sra_wide[W-1:0];
            icf_pkg::OP_AND:   r = a & b;
            icf_pkg::OP_XOR:   r = a ^ b;
            icf_pkg::OP_OR:    r = a | b;
            icf_pkg::OP_LT:    r = {{(W-1){1'b0}}, lt_ab};
            icf_pkg::OP_GT:    r = {{(W-1){1'b0}}, lt_ba};
            icf_pkg::OP_LE:    r = {{(W-1){1'b0}}, !lt_ba};
            icf_pkg::OP_GE:    r = {{(W-1){1'b0}}, !lt_ab};
            icf_pkg::OP_EQ:    r = {{(W-1){1'b0}}, (a == b)};
            icf_pkg::OP_NE:    r = {{(W-1){1'b0}}, (a != b)};
            icf_pkg::OP_LAND:  r = {{(W-1){1'b0}}, (a != '0) && (b != '0)};
            icf_pkg::OP_LOR:   r = {{(W-1){1'b0}}, (a != '0) || (b != '0)};
            icf_pkg::OP_SEQ:   r = b;
            default:           ok = 1'b0;
        endcase

        lane.valid = valid;
        lane.is_div = ok && ((req.req_type == icf_pkg::OP_DIV) ||
                             (req.req_type == icf_pkg::OP_MOD));
        lane.is_mod = (req.req_type == icf_pkg::OP_MOD);
        // signed: quotient sign is xor of signs, remainder follows the dividend
        lane.neg_res = sgn && ((req.req_type == icf_pkg::OP_MOD) ? na : (na != nb));
        lane.simple = r;
        lane.folded = ok;
        lane.rem = '0;
        lane.quo = sgn ? icf_pkg::mag32(a) : a;
        lane.divisor = sgn ? icf_pkg::mag32(b) : b;
    end

endmodule
`default_nettype wire

### design/icf_cell.sv
// one cell of the chain: a restoring divide step and a register for the item
`default_nettype none
module icf_cell (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            advance,
    input  wire icf_pkg::lane_t lane_in,
    output icf_pkg::lane_t lane_out
);
    localparam int unsigned W = icf_pkg::DATA_W;

    icf_pkg::lane_t lane_reg;
    icf_pkg::lane_t lane_next;
    logic [W:0]     trial;
    logic [W:0]     shifted;

    always_comb
    begin
        lane_next = lane_in;
        shifted = {lane_in.rem, lane_in.quo[W-1]};
        trial = shifted - {1'b0, lane_in.divisor};
        if (!trial[W])
        begin
            lane_next.rem = trial[W-1:0];
            lane_next.quo = {lane_in.quo[W-2:0], 1'b1};
        end
        else
        begin
            lane_next.rem = shifted[W-1:0];
            lane_next.quo = {lane_in.quo[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg <= '0;
        end
        else if (advance)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule
`default_nettype wire
